// ===== hw/rtl/sitad_pkg.sv =====
// Shared constants for the signed integer to ASCII decimal converter.
package sitad_pkg;

  // Number of decimal digit positions held by the converter.
  localparam int unsigned DIGITS = 10;
  localparam int unsigned IDX_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  localparam int unsigned MAG_W  = 32;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned DIG_W  = 4;

  // Reciprocal of ten scaled by 2^35; exact quotient for every 32-bit operand.
  localparam logic [MAG_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam int unsigned      RECIP_SHFT = 35;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

endpackage

// ===== hw/rtl/sitad_div10.sv =====
// Shared divide-by-ten unit: quotient and remainder of one unsigned magnitude.
module sitad_div10 (
  input  logic [sitad_pkg::MAG_W-1:0] mag_i,
  output logic [sitad_pkg::MAG_W-1:0] quot_o,
  output logic [sitad_pkg::DIG_W-1:0] rem_o
);

  logic [2*sitad_pkg::MAG_W-1:0] prod;
  logic [sitad_pkg::MAG_W-1:0]   times_ten;
  logic [sitad_pkg::MAG_W-1:0]   diff;

  // Multiply by the scaled reciprocal and keep the integer part.
  assign prod   = {{sitad_pkg::MAG_W{1'b0}}, mag_i}
                * {{sitad_pkg::MAG_W{1'b0}}, sitad_pkg::RECIP_TEN};
  assign quot_o = sitad_pkg::MAG_W'(prod >> sitad_pkg::RECIP_SHFT);

  // The remainder is the magnitude less ten times the quotient.
  assign times_ten = (quot_o << 3) + (quot_o << 1);
  assign diff      = mag_i - times_ten;
  assign rem_o     = diff[sitad_pkg::DIG_W-1:0];

endmodule

// ===== hw/rtl/signed_int_to_ascii_decimal.sv =====
// Signed integer to ASCII decimal text converter, top level.
// Takes one signed 32-bit integer per input word and sends its decimal text as
// one character per output word: a leading '-' for negative values, then the
// digits with leading zeros suppressed ('0' alone for zero), with last set on
// the final character. The most negative value gives "-2147483648". An input
// word is accepted in the idle state, the shared divide-by-ten unit then
// splits the magnitude into DIGITS (ten) digits, and the characters are then
// sent one per cycle while the output is not stalled. The input is stalled
// from acceptance until the last character has been loaded into the output
// register; the output register lets the next word be accepted while that
// character still waits to be taken.
module signed_int_to_ascii_decimal (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sitad_pkg::CHAR_W-1:0]  text_char_o,
  output logic                          last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  state_e                           state_q;
  logic                             neg_q;
  logic [sitad_pkg::MAG_W-1:0]      mag_q;
  logic [sitad_pkg::IDX_W-1:0]      cnt_q;
  logic [sitad_pkg::IDX_W-1:0]      top_q;
  logic [sitad_pkg::IDX_W-1:0]      top_d;
  logic [sitad_pkg::DIG_W-1:0]      digit_q [sitad_pkg::DIGITS];
  logic                             out_valid_q;
  logic [sitad_pkg::CHAR_W-1:0]     out_char_q;
  logic                             out_last_q;

  logic [sitad_pkg::MAG_W-1:0]      quot;
  logic [sitad_pkg::DIG_W-1:0]      rem;
  logic [sitad_pkg::MAG_W-1:0]      abs_val;
  logic                             out_load;
  logic                             conv_done;

  // Shared divide-by-ten unit, one digit per cycle.
  sitad_div10 u_div10 (
    .mag_i  (mag_q),
    .quot_o (quot),
    .rem_o  (rem)
  );

  // Two's complement magnitude; the most negative value wraps to 2^31 unsigned.
  assign abs_val = value_i[31] ? (~unsigned'(value_i) + 32'd1) : unsigned'(value_i);

  // Highest non-zero digit position seen so far.
  assign top_d     = (rem != '0) ? cnt_q : top_q;
  assign conv_done = (cnt_q == sitad_pkg::IDX_W'(sitad_pkg::DIGITS - 1));

  // The output register may take a new word when empty or being emptied.
  assign out_load = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign text_char_o = out_char_q;
  assign last_o      = out_last_q;

  // Digit store, written least significant digit first.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CONV) begin
      digit_q[cnt_q] <= rem;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      cnt_q       <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            neg_q   <= value_i[31];
            mag_q   <= abs_val;
            cnt_q   <= '0;
            top_q   <= '0;
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_q <= quot;
          top_q <= top_d;
          if (conv_done) begin
            cnt_q   <= top_d;
            state_q <= ST_EMIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            if (neg_q) begin
              // Sign goes first and never ends the text.
              out_char_q <= sitad_pkg::CHAR_MINUS;
              out_last_q <= 1'b0;
              neg_q      <= 1'b0;
            end else begin
              out_char_q <= sitad_pkg::CHAR_ZERO
                          + {{(sitad_pkg::CHAR_W-sitad_pkg::DIG_W){1'b0}}, digit_q[cnt_q]};
              out_last_q <= (cnt_q == '0);
              if (cnt_q == '0) begin
                state_q <= ST_IDLE;
              end else begin
                cnt_q <= cnt_q - 1'b1;
              end
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
